@@ rtl/core/tpsc_pkg.sv @@
// Shared constants and types for the two-point sensor calibration block.
package tpsc_pkg;

  localparam int HistDepth = 3;
  localparam int SlotW     = (HistDepth > 2) ? $clog2(HistDepth) : 1;

  localparam int TempW = 16;
  localparam int RngW  = 17;
  localparam int CorrW = 12;
  localparam int ErrW  = 10;
  localparam int TgtW  = 14;
  localparam int MinW  = 13;
  localparam int CfgW  = 14;
  localparam int SumW  = 18;

  // phase codes
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_FIRST  = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  // point_taken codes
  localparam logic [1:0] TAKEN_NONE   = 2'd0;
  localparam logic [1:0] TAKEN_FIRST  = 2'd1;
  localparam logic [1:0] TAKEN_FINISH = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_STAB_ERR  = 2'd0;
  localparam logic [1:0] CFG_TARGET    = 2'd1;
  localparam logic [1:0] CFG_MIN_DIFF  = 2'd2;
  localparam logic [1:0] CFG_RNG_CORR  = 2'd3;

  typedef struct packed {
    logic clr_all;
    logic clr_slot;
    logic wr_en;
  } hist_ctl_t;

endpackage

@@ rtl/core/tpsc_alu.sv @@
// Shared subtract/add unit: difference, magnitude and 17-bit saturation.
module tpsc_alu import tpsc_pkg::*; (
  input  logic signed [TempW-1:0] a,
  input  logic signed [TempW-1:0] b,
  input  logic signed [CorrW-1:0] c,
  output logic        [SumW-1:0]  mag,
  output logic signed [RngW-1:0]  sat
);

  localparam logic signed [SumW-1:0] SatHi = SumW'((1 <<< (RngW - 1)) - 1);
  localparam logic signed [SumW-1:0] SatLo = -SumW'(1 <<< (RngW - 1));

  logic signed [SumW-1:0] diff;

  assign diff = SumW'(a) - SumW'(b) + SumW'(c);
  assign mag  = diff[SumW-1] ? SumW'(-diff) : SumW'(diff);

  always_comb begin
    if (diff > SatHi) begin
      sat = RngW'(SatHi);
    end else if (diff < SatLo) begin
      sat = RngW'(SatLo);
    end else begin
      sat = RngW'(diff);
    end
  end

endmodule

@@ rtl/core/tpsc_hist.sv @@
// History rings for reference and sensor samples with write slot pointer.
module tpsc_hist import tpsc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  hist_ctl_t               ctl,
  input  logic signed [TempW-1:0] wr_ref,
  input  logic signed [TempW-1:0] wr_sen,
  input  logic        [SlotW-1:0] rd_idx,
  output logic signed [TempW-1:0] rd_ref,
  output logic signed [TempW-1:0] rd_sen,
  output logic signed [TempW-1:0] head_ref,
  output logic signed [TempW-1:0] head_sen
);

  logic signed [TempW-1:0] ref_mem_r [HistDepth];
  logic signed [TempW-1:0] sen_mem_r [HistDepth];
  logic        [SlotW-1:0] slot_r;
  logic        [SlotW-1:0] slot_nxt;

  assign slot_nxt = (slot_r == SlotW'(HistDepth - 1)) ? '0 : slot_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < HistDepth; k++) begin
        ref_mem_r[k] <= '0;
        sen_mem_r[k] <= '0;
      end
      slot_r <= '0;
    end else if (ctl.clr_all) begin
      // a sample of the start request opens the fresh rings at slot 0
      for (int k = 0; k < HistDepth; k++) begin
        ref_mem_r[k] <= (k == 0 && ctl.wr_en) ? wr_ref : '0;
        sen_mem_r[k] <= (k == 0 && ctl.wr_en) ? wr_sen : '0;
      end
      slot_r <= ctl.wr_en ? SlotW'(1) : '0;
    end else begin
      // a sample in the same request lands on top of the cleared slot
      if (ctl.wr_en) begin
        ref_mem_r[slot_r] <= wr_ref;
        sen_mem_r[slot_r] <= wr_sen;
        slot_r            <= slot_nxt;
      end else if (ctl.clr_slot) begin
        ref_mem_r[slot_r] <= '0;
        sen_mem_r[slot_r] <= '0;
      end
    end
  end

  assign rd_ref   = ref_mem_r[rd_idx];
  assign rd_sen   = sen_mem_r[rd_idx];
  assign head_ref = ref_mem_r[0];
  assign head_sen = sen_mem_r[0];

endmodule

@@ rtl/core/two_point_sensor_calibration.sv @@
// Start, idle, done or a first-point button press go straight to S_FIN; a scan walks
// each adjacent history pair through S_SCAN_A, S_SCAN_B and S_SCAN_C, stopping on a
// failed check, and finishing the second point adds S_RNG_REF and S_RNG_RAW for the
// ranges via the shared ALU. One request at a time; S_FIN waits on output stalls.
// Reset (rst_n low, synchronous): phase idle, histories and results zero,
// registers at their defaults; no clearing pass.
module two_point_sensor_calibration import tpsc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_start_req,
  input  logic                    in_button_pressed,
  input  logic                    in_sample_strobe,
  input  logic signed [TempW-1:0] in_reference_temp,
  input  logic signed [TempW-1:0] in_sensor_temp,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic        [1:0]       out_phase,
  output logic        [1:0]       out_point_taken,
  output logic                    out_heat_request,
  output logic                    out_fan_request,
  output logic signed [TempW-1:0] out_reference_low,
  output logic signed [TempW-1:0] out_raw_low,
  output logic signed [RngW-1:0]  out_reference_range,
  output logic signed [RngW-1:0]  out_raw_range,
  input  logic                    cfg_wr_en,
  input  logic        [1:0]       cfg_index,
  input  logic        [CfgW-1:0]  cfg_wdata
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SCAN_A  = 3'd1;
  localparam logic [2:0] S_SCAN_B  = 3'd2;
  localparam logic [2:0] S_SCAN_C  = 3'd3;
  localparam logic [2:0] S_RNG_REF = 3'd4;
  localparam logic [2:0] S_RNG_RAW = 3'd5;
  localparam logic [2:0] S_FIN     = 3'd6;

  // configuration
  logic        [ErrW-1:0]  err_r;
  logic        [TgtW-1:0]  tgt_r;
  logic        [MinW-1:0]  min_r;
  logic signed [CorrW-1:0] corr_r;

  // sequencer
  logic [2:0]       state_r, state_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [SlotW-1:0] idx_r, idx_nxt;
  logic             take_r, take_nxt;

  // captured request
  logic                    start_r, strobe_r;
  logic signed [TempW-1:0] rt_r, st_r;
  logic signed [TempW-1:0] rprev_r, rprev_nxt, sprev_r, sprev_nxt;
  logic signed [RngW-1:0]  rng_ref_r, rng_ref_nxt, rng_raw_r, rng_raw_nxt;

  // calibration results
  logic signed [TempW-1:0] prov_ref_r, prov_ref_nxt, prov_raw_r, prov_raw_nxt;
  logic signed [TempW-1:0] low_ref_r, low_ref_nxt, low_raw_r, low_raw_nxt;
  logic signed [RngW-1:0]  res_ref_r, res_ref_nxt, res_raw_r, res_raw_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  logic [1:0]              o_phase_r, o_taken_r;
  logic                    o_heat_r, o_fan_r;
  logic [1:0]              taken_nxt;

  logic                    accept, fire, fail;
  hist_ctl_t               hctl;
  logic signed [TempW-1:0] rd_ref, rd_sen, head_ref, head_sen;
  logic signed [TempW-1:0] alu_a, alu_b, tgt_s;
  logic signed [CorrW-1:0] alu_c;
  logic        [SumW-1:0]  alu_mag;
  logic signed [RngW-1:0]  alu_sat;

  assign tgt_s    = TempW'({2'b00, tgt_r});
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fire     = (state_r == S_FIN) && (!out_valid_r || out_ready);

  tpsc_hist u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (hctl),
    .wr_ref   (rt_r),
    .wr_sen   (st_r),
    .rd_idx   (idx_r),
    .rd_ref   (rd_ref),
    .rd_sen   (rd_sen),
    .head_ref (head_ref),
    .head_sen (head_sen)
  );

  tpsc_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .c   (alu_c),
    .mag (alu_mag),
    .sat (alu_sat)
  );

  // operand select and stability checks
  always_comb begin
    alu_a = rd_sen;
    alu_b = sprev_r;
    alu_c = '0;
    fail  = 1'b0;
    unique case (state_r)
      S_SCAN_A: begin
        fail = (sprev_r == '0) || (alu_mag > SumW'(err_r));
      end
      S_SCAN_B: begin
        alu_a = rd_ref;
        alu_b = rprev_r;
        fail  = alu_mag > SumW'(err_r);
      end
      S_SCAN_C: begin
        alu_a = rd_ref;
        alu_b = tgt_s;
        fail  = (phase_r == PH_SECOND) ? (alu_mag > SumW'(err_r))
                                       : (alu_mag < SumW'(min_r));
      end
      S_RNG_REF: begin
        alu_a = rt_r;
        alu_b = prov_ref_r;
      end
      S_RNG_RAW: begin
        alu_a = st_r;
        alu_b = prov_raw_r;
        alu_c = corr_r;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    take_nxt    = take_r;
    rprev_nxt   = rprev_r;
    sprev_nxt   = sprev_r;
    rng_ref_nxt = rng_ref_r;
    rng_raw_nxt = rng_raw_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt   = SlotW'(1);
          take_nxt  = 1'b0;
          rprev_nxt = head_ref;
          sprev_nxt = head_sen;
          priority if (in_start_req) begin
            state_nxt = S_FIN;
          end else if (phase_r == PH_FIRST) begin
            take_nxt  = in_button_pressed;
            state_nxt = in_button_pressed ? S_FIN : S_SCAN_A;
          end else if (phase_r == PH_SECOND) begin
            take_nxt  = in_button_pressed;
            state_nxt = in_button_pressed ? S_RNG_REF : S_SCAN_A;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_SCAN_A, S_SCAN_B: begin
        state_nxt = fail ? S_FIN : state_r + 3'd1;
      end
      S_SCAN_C: begin
        if (fail) begin
          state_nxt = S_FIN;
        end else if (idx_r == SlotW'(HistDepth - 1)) begin
          take_nxt  = 1'b1;
          state_nxt = (phase_r == PH_SECOND) ? S_RNG_REF : S_FIN;
        end else begin
          rprev_nxt = rd_ref;
          sprev_nxt = rd_sen;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SCAN_A;
        end
      end
      S_RNG_REF: begin
        rng_ref_nxt = alu_sat;
        state_nxt   = S_RNG_RAW;
      end
      S_RNG_RAW: begin
        rng_raw_nxt = alu_sat;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // commit of the request's effects
  always_comb begin
    phase_nxt    = phase_r;
    taken_nxt    = TAKEN_NONE;
    prov_ref_nxt = prov_ref_r;
    prov_raw_nxt = prov_raw_r;
    low_ref_nxt  = low_ref_r;
    low_raw_nxt  = low_raw_r;
    res_ref_nxt  = res_ref_r;
    res_raw_nxt  = res_raw_r;
    hctl         = '0;
    if (fire) begin
      priority if (start_r) begin
        hctl.clr_all = 1'b1;
        prov_ref_nxt = '0;
        prov_raw_nxt = '0;
        low_ref_nxt  = '0;
        low_raw_nxt  = '0;
        res_ref_nxt  = '0;
        res_raw_nxt  = '0;
        phase_nxt    = PH_FIRST;
      end else if (phase_r == PH_FIRST && take_r) begin
        prov_ref_nxt  = rt_r;
        prov_raw_nxt  = st_r;
        hctl.clr_slot = 1'b1;
        phase_nxt     = PH_SECOND;
        taken_nxt     = TAKEN_FIRST;
      end else if (phase_r == PH_SECOND && take_r) begin
        low_ref_nxt = prov_ref_r;
        low_raw_nxt = prov_raw_r;
        res_ref_nxt = rng_ref_r;
        res_raw_nxt = rng_raw_r;
        phase_nxt   = PH_DONE;
        taken_nxt   = TAKEN_FINISH;
      end else begin
      end
      // store the sample after the point decision
      hctl.wr_en = strobe_r &&
                   (phase_nxt == PH_FIRST || phase_nxt == PH_SECOND);
    end
  end

  assign out_valid_nxt = fire || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r  <= ErrW'(5);
      tgt_r  <= TgtW'(3600);
      min_r  <= MinW'(200);
      corr_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_STAB_ERR: err_r  <= cfg_wdata[ErrW-1:0];
        CFG_TARGET:   tgt_r  <= cfg_wdata[TgtW-1:0];
        CFG_MIN_DIFF: min_r  <= cfg_wdata[MinW-1:0];
        CFG_RNG_CORR: corr_r <= cfg_wdata[CorrW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      take_r      <= 1'b0;
      out_valid_r <= 1'b0;
      prov_ref_r  <= '0;
      prov_raw_r  <= '0;
      low_ref_r   <= '0;
      low_raw_r   <= '0;
      res_ref_r   <= '0;
      res_raw_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      take_r      <= take_nxt;
      out_valid_r <= out_valid_nxt;
      prov_ref_r  <= prov_ref_nxt;
      prov_raw_r  <= prov_raw_nxt;
      low_ref_r   <= low_ref_nxt;
      low_raw_r   <= low_raw_nxt;
      res_ref_r   <= res_ref_nxt;
      res_raw_r   <= res_raw_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    rprev_r   <= rprev_nxt;
    sprev_r   <= sprev_nxt;
    rng_ref_r <= rng_ref_nxt;
    rng_raw_r <= rng_raw_nxt;
    if (accept) begin
      start_r  <= in_start_req;
      strobe_r <= in_sample_strobe;
      rt_r     <= in_reference_temp;
      st_r     <= in_sensor_temp;
    end
    if (fire) begin
      o_phase_r           <= phase_nxt;
      o_taken_r           <= taken_nxt;
      o_heat_r            <= (phase_nxt == PH_SECOND) && (rt_r < tgt_s);
      o_fan_r             <= (phase_nxt == PH_FIRST) || (phase_nxt == PH_SECOND);
      out_reference_low   <= low_ref_nxt;
      out_raw_low         <= low_raw_nxt;
      out_reference_range <= res_ref_nxt;
      out_raw_range       <= res_raw_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_phase        = o_phase_r;
  assign out_point_taken  = o_taken_r;
  assign out_heat_request = o_heat_r;
  assign out_fan_request  = o_fan_r;

`ifndef SYNTHESIS
  a_scan_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_A || state_r == S_SCAN_C) |->
      (phase_r == PH_FIRST || phase_r == PH_SECOND))
    else $error("history scan outside a calibration point");

  a_range_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RNG_REF) |-> (phase_r == PH_SECOND && take_r && !start_r))
    else $error("range computed without taking the second point");

  a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_point_taken == TAKEN_FINISH) |-> (out_phase == PH_DONE))
    else $error("finished calibration without done phase");

  a_first_fan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_point_taken == TAKEN_FIRST) |->
      (out_phase == PH_SECOND && out_fan_request))
    else $error("first point taken without entering second point");

  a_heat_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_heat_request) |-> (out_phase == PH_SECOND))
    else $error("heat requested outside second point");
`endif

endmodule
